// File: rtl/core/ptcr_pkg.sv
// ----------------------------------------------------------------------------
// ptcr_pkg
// Shared types and constants for the page translation core with
// second-chance frame replacement.
// ----------------------------------------------------------------------------
package ptcr_pkg;

   // Field widths of the request and response beats.
   localparam int LINE_ADDR_W = 38;
   localparam int THREAD_W    = 2;
   localparam int PHYS_W      = 16;
   localparam int FRAME_OUT_W = 10;
   localparam int COUNT_W     = 32;

   // Lines per page. A power of two, so the page split is a shift and a mask.
   localparam int LINES_PER_PAGE = 64;
   localparam int LINE_W         = 6;

   // LFSR seed after reset.
   localparam logic [15:0] LFSR_SEED = 16'hACE1;

   // One request beat.
   typedef struct packed {
      logic [LINE_ADDR_W-1:0] line_addr;
      logic [THREAD_W-1:0]    thread;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic [PHYS_W-1:0]      phys_line_addr;
      logic [FRAME_OUT_W-1:0] frame;
      logic                   page_hit;
      logic                   evicted;
      logic [COUNT_W-1:0]     miss_total;
      logic [COUNT_W-1:0]     evict_total;
   } rsp_type;

   // Per-frame status word held in the status memory.
   typedef struct packed {
      logic valid;
      logic refd;
   } fstat_type;

endpackage

// File: rtl/core/ptcr_ram.sv
// ----------------------------------------------------------------------------
// ptcr_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ptcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port; a read of the entry being
   // written returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/ptcr_div.sv
// ----------------------------------------------------------------------------
// ptcr_div
// Remainder of a 16-bit value by a constant divisor, using reciprocal
// multiplication; the quotient is registered first, then the remainder, and done rises as the remainder is loaded.
// ----------------------------------------------------------------------------
module ptcr_div #(
   parameter int DIVISOR = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   output logic        done,
   output logic [15:0] remainder
);

   // Reciprocal rounded up; the quotient is exact for every 16-bit dividend
   // with a divisor up to 65536.
   localparam longint unsigned RECIP =
      ((64'd1 << 32) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [32:0] RECIP_W   = 33'(RECIP);
   localparam logic [32:0] DIVISOR_W = 33'(DIVISOR);

   logic        step_ff;
   logic        done_ff;
   logic [15:0] dvd_ff;
   logic [15:0] quo_ff;
   logic [15:0] rem_ff;
   logic [48:0] prod;
   logic [32:0] back;

   // The reciprocal product gives the quotient, registered on start; the remainder follows from it.
   assign prod = {33'b0, dividend} * {16'b0, RECIP_W};
   assign back = {17'b0, quo_ff} * DIVISOR_W;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= start;
         done_ff <= step_ff;
      end
      if (start) begin
         dvd_ff <= dividend;
         quo_ff <= prod[47:32];
      end
      if (step_ff) begin
         rem_ff <= 16'({17'b0, dvd_ff} - back);
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/page_translation_clock_replacement_core.sv
// ----------------------------------------------------------------------------
// page_translation_clock_replacement_core
// Translates virtual line addresses to physical line addresses inside a
// per-thread frame partition, with a per-thread last-translation register,
// an optional random probe and second-chance (clock) victim selection.
//
//   Channel  Ports                    Direction  Beat
//   req      req_valid/ready/data     in         line_addr, thread
//   rsp      rsp_valid/ready/data     out        translation result
//   csr      csr_valid/ready/wdata    in         random_probe_enable
//
// One request is worked on at a time. The page split is a shift taken at
// acceptance, then the last-translation check follows; a repeat ends
// there. Otherwise the partition is searched one frame per cycle through
// the status and tag memories. On a page miss with the probe enabled, the
// LFSR is stepped and reduced modulo the partition size, and the probed
// frame is taken if free. Otherwise, or with the probe off, the clock scan
// examines one frame per cycle, at most partition size + 1 frames, through
// the registered status read. A stall on the response holds the result.
// After reset a clearing pass over all FRAMES entries zeroes the frame
// status memory; no request is taken until it ends. Configuration writes
// are taken in every cycle. A finished result waits in the output register
// while the next request is accepted.
// ----------------------------------------------------------------------------
module page_translation_clock_replacement_core #(
   parameter int FRAMES         = 1024,
   parameter int THREADS        = 4,
   parameter int VPN_BITS       = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptcr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptcr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata
);

   import ptcr_pkg::*;

   localparam int PER_RAW = FRAMES / THREADS;
   localparam int PER     = (PER_RAW == 0) ? 1 : PER_RAW;
   localparam int FW      = $clog2(FRAMES);
   localparam int TW      = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int OW      = $clog2(PER + 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_SEARCH,
      ST_PDIV,
      ST_PROBE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [FW-1:0]          clr_ff, clr_in;
   logic [TW-1:0]          tm_ff, tm_in;
   logic [FW-1:0]          start_ff, start_in;
   logic [VPN_BITS-1:0]    vpn_ff, vpn_in;
   logic [LINE_W-1:0]      line_ff, line_in;
   logic [OW-1:0]          off_ff, off_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [FW-1:0]          rd_addr_ff, rd_addr_in;
   logic                   fwd_ff, fwd_in;
   logic [FW-1:0]          fr_ff, fr_in;
   logic                   hit_ff, hit_in;
   logic                   ev_ff, ev_in;
   logic [15:0]            lfsr_ff, lfsr_in;
   logic [COUNT_W-1:0]     miss_ff, miss_in;
   logic [COUNT_W-1:0]     evict_ff, evict_in;
   logic                   probe_en_ff, probe_en_in;
   logic [VPN_BITS-1:0]    last_page_ff [THREADS];
   logic [VPN_BITS-1:0]    last_page_in [THREADS];
   logic [FW-1:0]          last_frame_ff [THREADS];
   logic [FW-1:0]          last_frame_in [THREADS];
   logic [THREADS-1:0]     last_valid_ff, last_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Memory ports.
   logic                   st_we;
   logic [FW-1:0]          waddr;
   fstat_type              st_wdata;
   fstat_type              st_rdata;
   logic                   tg_we;
   logic [VPN_BITS-1:0]    tg_rdata;
   logic [FW-1:0]          raddr;

   // Probe offset unit ports.
   logic                   div_start;
   logic [15:0]            div_dvd;
   logic                   div_done;
   logic [15:0]            div_rem;

   logic [15:0]            lfsr_next;
   logic [TW-1:0]          req_tm;
   logic [FW-1:0]          req_start;
   logic                   eff_ref;
   logic [31:0]            phys_full;

   // Frame status memory (valid and reference bits), cleared after reset.
   ptcr_ram #(
      .WIDTH($bits(fstat_type)),
      .DEPTH(FRAMES)
   ) u_stat_ram (
      .clock(clock),
      .we   (st_we),
      .waddr(waddr),
      .wdata(st_wdata),
      .raddr(raddr),
      .rdata(st_rdata)
   );

   // Frame tag memory, written when a frame is allocated.
   ptcr_ram #(
      .WIDTH(VPN_BITS),
      .DEPTH(FRAMES)
   ) u_tag_ram (
      .clock(clock),
      .we   (tg_we),
      .waddr(waddr),
      .wdata(vpn_ff),
      .raddr(raddr),
      .rdata(tg_rdata)
   );

   // Probe offset: stepped LFSR value modulo the partition size.
   ptcr_div #(
      .DIVISOR(PER)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .done     (div_done),
      .remainder(div_rem)
   );

   // Fibonacci LFSR step, taps 16, 14, 13 and 11.
   assign lfsr_next = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};
   assign div_dvd   = lfsr_next;

   // Thread folded into range and its partition's first frame.
   always_comb begin
      logic [5:0]  tv;
      logic [19:0] sv;
      tv = {4'b0, req_data.thread};
      for (int k = 0; k < 4; k++) begin
         if (tv >= 6'(THREADS)) begin
            tv = tv - 6'(THREADS);
         end
      end
      sv = 20'(tv) * 20'(PER);
      for (int k = 0; k < 3; k++) begin
         if (sv >= 20'(FRAMES)) begin
            sv = sv - 20'(FRAMES);
         end
      end
      req_tm    = TW'(tv);
      req_start = FW'(sv);
   end

   // Reference bit seen by the scan, with a clear just written forwarded.
   assign eff_ref   = st_rdata.refd & ~fwd_ff;
   assign phys_full = 32'(fr_ff) * 32'(LINES_PER_PAGE) + 32'(line_ff);

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      tm_in         = tm_ff;
      start_in      = start_ff;
      vpn_in        = vpn_ff;
      line_in       = line_ff;
      off_in        = off_ff;
      rd_vld_in     = 1'b0;
      fr_in         = fr_ff;
      hit_in        = hit_ff;
      ev_in         = ev_ff;
      lfsr_in       = lfsr_ff;
      miss_in       = miss_ff;
      evict_in      = evict_ff;
      probe_en_in   = csr_valid ? csr_wdata : probe_en_ff;
      last_page_in  = last_page_ff;
      last_frame_in = last_frame_ff;
      last_valid_in = last_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = (rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff;
      st_we         = 1'b0;
      tg_we         = 1'b0;
      waddr         = rd_addr_ff;
      st_wdata      = '{valid: 1'b1, refd: 1'b1};
      raddr         = start_ff + FW'(off_ff);
      div_start     = 1'b0;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            st_we    = 1'b1;
            waddr    = clr_ff;
            st_wdata = '{valid: 1'b0, refd: 1'b0};
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == FW'(FRAMES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               tm_in    = req_tm;
               start_in = req_start;
               vpn_in   = VPN_BITS'(req_data.line_addr >> LINE_W);
               line_in  = req_data.line_addr[LINE_W-1:0];
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            off_in = '0;
            if (last_valid_ff[tm_ff] && last_page_ff[tm_ff] == vpn_ff) begin
               fr_in    = last_frame_ff[tm_ff];
               hit_in   = 1'b1;
               ev_in    = 1'b0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // Issue one tag read per cycle; compare the one that returns.
            if (off_ff < OW'(PER)) begin
               rd_vld_in = 1'b1;
               off_in    = off_ff + 1'b1;
            end
            if (rd_vld_ff && st_rdata.valid && tg_rdata == vpn_ff) begin
               st_we                = 1'b1;
               rd_vld_in            = 1'b0;
               fr_in                = rd_addr_ff;
               hit_in               = 1'b1;
               ev_in                = 1'b0;
               last_page_in[tm_ff]  = vpn_ff;
               last_frame_in[tm_ff] = rd_addr_ff;
               last_valid_in[tm_ff] = 1'b1;
               state_in             = ST_DONE;
            end else if (!rd_vld_ff && off_ff == OW'(PER)) begin
               hit_in = 1'b0;
               off_in = '0;
               if (probe_en_ff) begin
                  lfsr_in   = lfsr_next;
                  div_start = 1'b1;
                  state_in  = ST_PDIV;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_PDIV: begin
            if (div_done) begin
               raddr    = start_ff + FW'(div_rem);
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // The probe takes its frame only if the frame is free.
            if (!st_rdata.valid) begin
               st_we                = 1'b1;
               tg_we                = 1'b1;
               fr_in                = rd_addr_ff;
               ev_in                = 1'b0;
               miss_in              = miss_ff + 1'b1;
               last_page_in[tm_ff]  = vpn_ff;
               last_frame_in[tm_ff] = rd_addr_ff;
               last_valid_in[tm_ff] = 1'b1;
               state_in             = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Clock hand: one frame per cycle, wrapping within the partition.
            rd_vld_in = 1'b1;
            off_in    = (off_ff == OW'(PER - 1)) ? '0 : off_ff + 1'b1;
            if (rd_vld_ff) begin
               if (!st_rdata.valid || !eff_ref) begin
                  st_we                = 1'b1;
                  tg_we                = 1'b1;
                  rd_vld_in            = 1'b0;
                  fr_in                = rd_addr_ff;
                  ev_in                = st_rdata.valid;
                  miss_in              = miss_ff + 1'b1;
                  evict_in             = evict_ff + COUNT_W'(st_rdata.valid);
                  last_page_in[tm_ff]  = vpn_ff;
                  last_frame_in[tm_ff] = rd_addr_ff;
                  last_valid_in[tm_ff] = 1'b1;
                  state_in             = ST_DONE;
               end else begin
                  st_we    = 1'b1;
                  st_wdata = '{valid: 1'b1, refd: 1'b0};
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.phys_line_addr = PHYS_W'(phys_full);
               rsp_in.frame          = FRAME_OUT_W'(fr_ff);
               rsp_in.page_hit       = hit_ff;
               rsp_in.evicted        = ev_ff;
               rsp_in.miss_total     = miss_ff;
               rsp_in.evict_total    = evict_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Track the read address and whether it collides with this write.
      rd_addr_in = raddr;
      fwd_in     = st_we && (waddr == raddr);
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         fwd_ff        <= 1'b0;
         lfsr_ff       <= LFSR_SEED;
         miss_ff       <= '0;
         evict_ff      <= '0;
         probe_en_ff   <= 1'b1;
         last_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rd_vld_ff     <= rd_vld_in;
         fwd_ff        <= fwd_in;
         lfsr_ff       <= lfsr_in;
         miss_ff       <= miss_in;
         evict_ff      <= evict_in;
         probe_en_ff   <= probe_en_in;
         last_valid_ff <= last_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      tm_ff         <= tm_in;
      start_ff      <= start_in;
      vpn_ff        <= vpn_in;
      line_ff       <= line_in;
      off_ff        <= off_in;
      rd_addr_ff    <= rd_addr_in;
      fr_ff         <= fr_in;
      hit_ff        <= hit_in;
      ev_ff         <= ev_in;
      last_page_ff  <= last_page_in;
      last_frame_ff <= last_frame_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

// File: tb/sv/page_translation_clock_replacement_core_tb.sv
// ----------------------------------------------------------------------------
// page_translation_clock_replacement_core_tb
// Drives translation requests with random burst gaps and response stalls,
// predicts every result with a behavioral copy of the partitioned clock
// replacement scheme and compares each response beat field by field.
// ----------------------------------------------------------------------------

// Scoreboard: holds the translation state and the queue of expected beats.
class translation_scoreboard;
   bit          frame_valid [1024];
   bit          frame_ref [1024];
   logic [31:0] frame_tag [1024];
   logic [31:0] last_page [4];
   logic [9:0]  last_frame [4];
   bit          last_valid [4];
   logic [15:0] probe_lfsr;
   logic [31:0] page_misses;
   logic [31:0] evict_count;
   bit          probe_enable;
   ptcr_pkg::rsp_type expected_q[$];
   int          error_count;
   int          hit_count;
   int          evict_seen;

   function new();
      probe_lfsr   = ptcr_pkg::LFSR_SEED;
      page_misses  = 0;
      evict_count  = 0;
      probe_enable = 1'b1;
      error_count  = 0;
      hit_count    = 0;
      evict_seen   = 0;
      foreach (frame_valid[i]) begin
         frame_valid[i] = 0;
         frame_ref[i]   = 0;
         frame_tag[i]   = '0;
      end
      foreach (last_valid[i]) begin
         last_valid[i] = 0;
         last_page[i]  = '0;
         last_frame[i] = '0;
      end
   endfunction

   // Pick a victim frame: optional random probe, then second-chance scan.
   function logic [9:0] choose_victim(int base);
      int   off;
      logic [9:0] v;
      off = 0;
      if (probe_enable) begin
         probe_lfsr = {probe_lfsr[0] ^ probe_lfsr[2] ^ probe_lfsr[3] ^ probe_lfsr[5],
                       probe_lfsr[15:1]};
         v = 10'(base + int'(probe_lfsr[7:0]));
         if (!frame_valid[v]) return v;
      end
      forever begin
         v = 10'(base + (off % 256));
         if (!frame_valid[v] || !frame_ref[v]) return v;
         frame_ref[v] = 0;
         off++;
      end
   endfunction

   // Note an accepted request and queue its expected response beat.
   function void note_request(ptcr_pkg::req_type r);
      logic [31:0] vpn;
      logic [5:0]  line;
      int          t;
      int          base;
      logic [9:0]  fr;
      bit          hit;
      bit          ev;
      ptcr_pkg::rsp_type e;
      vpn  = r.line_addr[37:6];
      line = r.line_addr[5:0];
      t    = int'(r.thread);
      base = t * 256;
      hit  = 0;
      ev   = 0;
      fr   = '0;
      if (last_valid[t] && last_page[t] == vpn) begin
         fr  = last_frame[t];
         hit = 1;
      end else begin
         for (int i = 0; i < 256; i++) begin
            if (frame_valid[base+i] && frame_tag[base+i] == vpn) begin
               fr  = 10'(base + i);
               hit = 1;
               break;
            end
         end
         if (!hit) begin
            fr = choose_victim(base);
            if (frame_valid[fr]) begin
               ev = 1;
               evict_count++;
            end
            frame_valid[fr] = 1;
            frame_tag[fr]   = vpn;
            page_misses++;
         end
         frame_ref[fr] = 1;
         last_page[t]  = vpn;
         last_frame[t] = fr;
         last_valid[t] = 1;
      end
      e.phys_line_addr = {fr, line};
      e.frame          = fr;
      e.page_hit       = hit;
      e.evicted        = ev;
      e.miss_total     = page_misses;
      e.evict_total    = evict_count;
      expected_q.push_back(e);
   endfunction

   // One line per mismatch, counted.
   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   // Compare an accepted response beat with the oldest expectation.
   task check_response(ptcr_pkg::rsp_type g);
      ptcr_pkg::rsp_type e;
      if (expected_q.size() == 0) begin
         report("unexpected beat", 0, 0);
         return;
      end
      e = expected_q.pop_front();
      if (e.page_hit) hit_count++;
      if (e.evicted) evict_seen++;
      if (g.phys_line_addr !== e.phys_line_addr)
         report("phys_line_addr", g.phys_line_addr, e.phys_line_addr);
      if (g.frame !== e.frame) report("frame", g.frame, e.frame);
      if (g.page_hit !== e.page_hit) report("page_hit", g.page_hit, e.page_hit);
      if (g.evicted !== e.evicted) report("evicted", g.evicted, e.evicted);
      if (g.miss_total !== e.miss_total) report("miss_total", g.miss_total, e.miss_total);
      if (g.evict_total !== e.evict_total)
         report("evict_total", g.evict_total, e.evict_total);
   endtask
endclass

module page_translation_clock_replacement_core_tb;
   import ptcr_pkg::*;

   localparam int IDLE_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_wdata;

   translation_scoreboard sb;
   int idle_cycles;
   int items_sent;
   int stall_mode;
   logic [31:0] page_pool [16];

   page_translation_clock_replacement_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver: stalls follow a slowly changing pattern, with quiet stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 1) != 0);
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Response checking and watchdog on accepted beats.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Send one request beat and hold it until accepted. Valid stays high so
   // that the next beat of a burst can follow; callers drop it before a gap.
   task send_request(logic [37:0] addr, logic [1:0] thr);
      req_valid <= 1'b1;
      req_data  <= '{line_addr: addr, thread: thr};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(req_data);
      items_sent++;
   endtask

   // Wait until every expected beat has come, plus settling time.
   task drain_results();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   // Write the probe enable register while the block is idle.
   task write_probe_enable(logic v);
      drain_results();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.probe_enable = v;
      csr_valid <= 1'b0;
   endtask

   // Random address: mostly pages from a small pool so hits and evictions occur.
   function logic [37:0] pick_addr();
      logic [31:0] vpn;
      case ($urandom_range(0, 9))
         0, 1: vpn = $urandom;
         default: vpn = page_pool[$urandom_range(0, 15)] + $urandom_range(0, 300);
      endcase
      return {vpn, 6'($urandom)};
   endfunction

   task random_phase(int count);
      int burst;
      int n;
      n = 0;
      while (n < count) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && n < count; b++) begin
            send_request(pick_addr(), 2'($urandom_range(0, 3)));
            n++;
         end
         if ($urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   endtask

   initial begin
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_wdata   = 1'b0;
      idle_cycles = 0;
      items_sent  = 0;
      foreach (page_pool[i]) page_pool[i] = $urandom;
      page_pool[0] = 32'h0;
      page_pool[1] = 32'hFFFF_FEC0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, repeats, aliasing threads, probe off.
      send_request(38'h0, 2'd0);
      send_request(38'h0, 2'd0);
      send_request(38'h3F, 2'd0);
      send_request(38'h3F_FFFF_FFFF, 2'd3);
      send_request(38'h3F_FFFF_FFFF, 2'd3);
      send_request(38'h0, 2'd1);
      send_request(38'h0, 2'd2);
      send_request(38'h2A_AAAA_AAAA, 2'd1);
      send_request(38'h15_5555_5555, 2'd2);
      send_request(38'h40, 2'd0);
      send_request(38'h0, 2'd0);
      write_probe_enable(1'b0);
      send_request(38'h80, 2'd0);
      send_request(38'h1_0000_0000, 2'd3);
      send_request(38'h0, 2'd0);
      write_probe_enable(1'b1);

      // Random phases across both register settings, with pressure pauses.
      random_phase(250);
      drain_results();
      write_probe_enable(1'b0);
      random_phase(150);
      write_probe_enable(1'b1);
      random_phase(200);
      write_probe_enable(1'b0);
      random_phase(150);

      drain_results();
      $display("Sent %0d requests: %0d hits, %0d evictions, probe on and off.",
               items_sent, sb.hit_count, sb.evict_seen);
      if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

// File: filelist.f
rtl/core/ptcr_pkg.sv
rtl/core/ptcr_ram.sv
rtl/core/ptcr_div.sv
rtl/core/page_translation_clock_replacement_core.sv
tb/sv/page_translation_clock_replacement_core_tb.sv
